/* rtl/i2cms_pkg.sv */
package i2cms_pkg;

  // Sizing
  localparam int MAX_SEGMENTS = 16;
  localparam int LENGTH_BITS  = 16;
  localparam int IDX_W        = 16;
  localparam int SEG_W        = 5;

  localparam logic [LENGTH_BITS-1:0] IDX_MAX = '1;

  // Status register 1 bit positions
  localparam int SR_SB   = 0;
  localparam int SR_ADDR = 1;
  localparam int SR_BTF  = 2;
  localparam int SR_RXNE = 6;
  localparam int SR_TXE  = 7;
  localparam int SR_AF   = 10;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_DONE   = 2'd1,
    ST_NACK   = 2'd2,
    ST_BUSERR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACK_KEEP = 2'd0,
    ACK_ON   = 2'd1,
    ACK_OFF  = 2'd2
  } ack_t;

  typedef enum logic [1:0] {
    FC_NONE = 2'd0,
    FC_AF   = 2'd1,
    FC_ALL  = 2'd2
  } flag_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_EVENT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [4:0]  segment_count;
    logic [15:0] status_word;
    logic        transmitting;
    logic [7:0]  rx_byte;
    logic [6:0]  seg_address;
    logic        seg_read;
    logic [15:0] seg_length;
    logic [7:0]  tx_byte;
  } item_t;

  typedef struct packed {
    logic             handled;
    logic             clear_start;
    logic             start_request;
    ack_t             ack_action;
    logic             data_write_valid;
    logic [7:0]       data_write_value;
    flag_t            flag_clear;
    logic             rx_store_valid;
    logic [IDX_W-1:0] rx_index;
    logic             segment_advance;
    logic [IDX_W-1:0] byte_index_out;
    status_t          transfer_status;
  } result_t;

  // Flow control between the pipeline stages
  typedef struct packed {
    logic advance;
    logic fire;
  } flow_t;

endpackage

/* rtl/i2cms_in_stage.sv */
module i2cms_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cms_pkg::item_t    in_item,
  input  i2cms_pkg::flow_t    flow,
  output logic                s1_valid,
  output i2cms_pkg::item_t    s1_item
);

  logic             s1_vld_r;
  i2cms_pkg::item_t item_r;

  // Hold the staged item while the result side cannot take it
  assign in_stall = s1_vld_r & ~flow.advance;

  // Control: stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!in_stall) begin
      s1_vld_r <= in_valid;
    end
  end

  // Payload: capture on transfer
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = s1_vld_r;
  assign s1_item  = item_r;

endmodule

/* rtl/i2cms_step.sv */
module i2cms_step (
  input  logic                clk,
  input  logic                rst_n,
  input  i2cms_pkg::flow_t    flow,
  input  i2cms_pkg::item_t    item,
  output i2cms_pkg::result_t  res
);

  localparam int LB = i2cms_pkg::LENGTH_BITS;

  logic [LB-1:0]                  bi_r, bi_nxt;
  logic [i2cms_pkg::SEG_W-1:0]    seg_r, seg_nxt;
  i2cms_pkg::status_t             st_r, st_nxt;

  logic [LB:0]                    bi_inc;
  logic [LB:0]                    len_x;
  logic [LB-1:0]                  bi_bump;
  logic [i2cms_pkg::SEG_W-1:0]    cnt;
  logic [15:0]                    sr;
  logic                           txe_only;
  logic                           end_seg;

  assign sr       = item.status_word;
  assign bi_inc   = {1'b0, bi_r} + {{LB{1'b0}}, 1'b1};
  assign len_x    = {1'b0, item.seg_length[LB-1:0]};
  assign bi_bump  = (bi_r == i2cms_pkg::IDX_MAX) ? bi_r : bi_inc[LB-1:0];
  assign txe_only = (sr == (16'd1 << i2cms_pkg::SR_TXE));

  // Clamp the segment count to at least one and at most the maximum
  always_comb begin
    cnt = item.segment_count;
    if (cnt == '0) begin
      cnt = {{(i2cms_pkg::SEG_W-1){1'b0}}, 1'b1};
    end
    if (int'(cnt) > i2cms_pkg::MAX_SEGMENTS) begin
      cnt = i2cms_pkg::SEG_W'(i2cms_pkg::MAX_SEGMENTS);
    end
  end

  // Decode the event against the sequencer state
  always_comb begin
    res     = '0;
    bi_nxt  = bi_r;
    seg_nxt = seg_r;
    st_nxt  = st_r;
    end_seg = 1'b0;

    if (item.kind == i2cms_pkg::KIND_START) begin
      seg_nxt           = cnt;
      bi_nxt            = '0;
      st_nxt            = i2cms_pkg::ST_BUSY;
      res.handled       = 1'b1;
      res.start_request = 1'b1;
    end else if (sr != '0) begin
      res.handled = 1'b1;
      if (st_r != i2cms_pkg::ST_BUSY) begin
        // idle: drop the event
      end else if (sr[i2cms_pkg::SR_SB]) begin
        res.clear_start      = 1'b1;
        res.data_write_valid = 1'b1;
        res.data_write_value = {item.seg_address, item.seg_read};
      end else if (sr[i2cms_pkg::SR_AF]) begin
        res.flag_clear = i2cms_pkg::FC_AF;
        st_nxt         = i2cms_pkg::ST_NACK;
      end else if (sr[i2cms_pkg::SR_ADDR] | sr[i2cms_pkg::SR_TXE] |
                   sr[i2cms_pkg::SR_BTF]  | sr[i2cms_pkg::SR_RXNE]) begin
        // a lone TXE waits for the following event
        if (!txe_only) begin
          res.ack_action = (bi_inc == len_x) ? i2cms_pkg::ACK_OFF : i2cms_pkg::ACK_ON;
          if (item.transmitting) begin
            if ({1'b0, bi_r} < len_x) begin
              res.data_write_valid = 1'b1;
              res.data_write_value = item.tx_byte;
              bi_nxt               = bi_bump;
            end else begin
              end_seg = 1'b1;
            end
          end else if (sr[i2cms_pkg::SR_RXNE]) begin
            res.rx_store_valid = 1'b1;
            res.rx_index       = i2cms_pkg::IDX_W'(bi_r);
            bi_nxt             = bi_bump;
            end_seg            = (bi_inc >= len_x);
          end
        end
      end else begin
        res.flag_clear = i2cms_pkg::FC_ALL;
        st_nxt         = i2cms_pkg::ST_BUSERR;
      end
    end

    // Finish the transfer or move on to the next segment
    if (end_seg) begin
      if (seg_r <= i2cms_pkg::SEG_W'(1)) begin
        seg_nxt = '0;
        st_nxt  = i2cms_pkg::ST_DONE;
      end else begin
        seg_nxt             = seg_r - i2cms_pkg::SEG_W'(1);
        bi_nxt              = '0;
        res.start_request   = 1'b1;
        res.segment_advance = 1'b1;
      end
    end

    res.byte_index_out  = i2cms_pkg::IDX_W'(bi_nxt);
    res.transfer_status = st_nxt;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bi_r  <= '0;
      seg_r <= '0;
      st_r  <= i2cms_pkg::ST_DONE;
    end else if (flow.fire) begin
      bi_r  <= bi_nxt;
      seg_r <= seg_nxt;
      st_r  <= st_nxt;
    end
  end

endmodule

/* rtl/i2cms_out_stage.sv */
module i2cms_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  i2cms_pkg::result_t  res,
  output i2cms_pkg::flow_t    flow,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cms_pkg::result_t  out_res
);

  logic               out_vld_r;
  i2cms_pkg::result_t res_r;

  // Advance whenever the result register is empty or being drained
  assign flow.advance = ~out_vld_r | ~out_stall;
  assign flow.fire    = s1_valid & flow.advance;

  // Control: result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (flow.advance) begin
      out_vld_r <= s1_valid;
    end
  end

  // Payload: load on each new result
  always_ff @(posedge clk) begin
    if (flow.fire) begin
      res_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = res_r;

endmodule

/* rtl/i2c_master_event_sequencer_core.sv */
// I2C master transfer sequencer.
// Input channel (in_*): a start item (kind 0) loads the segment count and
// asks for a start condition; an event item (kind 1) carries the controller
// status word, transmitter-mode bit, received byte and the current segment's
// address, direction, length and transmit byte. Each accepted item yields
// exactly one result on the output channel (out_*): start/ACK/data-register
// actions, flag clears, receive store position, segment advance, new byte
// index and transfer status.
// Flow: an accepted item is held in the input register, decoded by one level
// of logic, and its result loaded into the result register. Throughput is one
// item per cycle while out_stall is low; the byte index, segment counter and
// status are updated when the item moves into the result register.
// Stall: while out_stall holds a result, one more item may sit in the input
// register; in_stall rises only when both registers are full.
// Reset (rst_n low, synchronous): both registers empty, byte index and
// segment count zero, status done, so events are ignored until a start item.
module i2c_master_event_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [4:0]  in_segment_count,
  input  logic [15:0] in_status_word,
  input  logic        in_transmitting,
  input  logic [7:0]  in_rx_byte,
  input  logic [6:0]  in_seg_address,
  input  logic        in_seg_read,
  input  logic [15:0] in_seg_length,
  input  logic [7:0]  in_tx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_handled,
  output logic        out_clear_start,
  output logic        out_start_request,
  output logic [1:0]  out_ack_action,
  output logic        out_data_write_valid,
  output logic [7:0]  out_data_write_value,
  output logic [1:0]  out_flag_clear,
  output logic        out_rx_store_valid,
  output logic [15:0] out_rx_index,
  output logic        out_segment_advance,
  output logic [15:0] out_byte_index_out,
  output logic [1:0]  out_transfer_status
);

  i2cms_pkg::item_t   in_item;
  i2cms_pkg::item_t   s1_item;
  i2cms_pkg::result_t step_res;
  i2cms_pkg::result_t out_res;
  i2cms_pkg::flow_t   flow;
  logic               s1_valid;

  // Pack the input fields
  always_comb begin
    in_item.kind          = i2cms_pkg::kind_t'(in_kind);
    in_item.segment_count = in_segment_count;
    in_item.status_word   = in_status_word;
    in_item.transmitting  = in_transmitting;
    in_item.rx_byte       = in_rx_byte;
    in_item.seg_address   = in_seg_address;
    in_item.seg_read      = in_seg_read;
    in_item.seg_length    = in_seg_length;
    in_item.tx_byte       = in_tx_byte;
  end

  i2cms_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .flow     (flow),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  i2cms_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .flow  (flow),
    .item  (s1_item),
    .res   (step_res)
  );

  i2cms_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res       (step_res),
    .flow      (flow),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Unpack the result fields
  assign out_handled          = out_res.handled;
  assign out_clear_start      = out_res.clear_start;
  assign out_start_request    = out_res.start_request;
  assign out_ack_action       = out_res.ack_action;
  assign out_data_write_valid = out_res.data_write_valid;
  assign out_data_write_value = out_res.data_write_value;
  assign out_flag_clear       = out_res.flag_clear;
  assign out_rx_store_valid   = out_res.rx_store_valid;
  assign out_rx_index         = out_res.rx_index;
  assign out_segment_advance  = out_res.segment_advance;
  assign out_byte_index_out   = out_res.byte_index_out;
  assign out_transfer_status  = out_res.transfer_status;

endmodule

/* rtl/i2cms_checker.sv */
module i2cms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_start_request,
  input logic        out_data_write_valid,
  input logic [7:0]  out_data_write_value,
  input logic [1:0]  out_flag_clear,
  input logic        out_rx_store_valid,
  input logic        out_segment_advance,
  input logic [15:0] out_byte_index_out,
  input logic [1:0]  out_transfer_status
);

  // Hold a stalled result transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_index_out)
      && $stable(out_transfer_status) && $stable(out_data_write_value))
    else $error("result changed while stalled");

  // A segment advance restarts the bus at byte zero of a busy transfer
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_segment_advance |-> out_start_request
      && out_byte_index_out == 16'd0
      && out_transfer_status == i2cms_pkg::ST_BUSY)
    else $error("segment advance without restart");

  // Idle data byte reads as zero
  a_dw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data_write_valid |-> out_data_write_value == 8'd0)
    else $error("data byte without write");

  // A flag clear ends the event: no data write and no store
  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flag_clear != i2cms_pkg::FC_NONE |->
      !out_data_write_valid && !out_rx_store_valid
      && out_transfer_status != i2cms_pkg::ST_BUSY)
    else $error("flag clear mixed with data action");

endmodule

bind i2c_master_event_sequencer_core i2cms_checker u_chk (.*);
